/* hw/rtl/gwp_pkg.sv */
// ----------------------------------------------------------------------------
// gwp_pkg
// Shared types, constants and tables for the Gumbel weight perturber.
// ----------------------------------------------------------------------------
`default_nettype none

package gwp_pkg;

   localparam int unsigned WEIGHT_FRAC_BITS_DEF = 24;
   localparam int unsigned UNIFORM_BITS_DEF     = 24;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] REG_NOISE_SCALE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SEED        = 1'd1;
   localparam logic [15:0] NOISE_SCALE_RESET = 16'd256;

   localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;

   localparam logic [31:0] U_LO = 32'd429;
   localparam logic [31:0] U_HI = 32'hFFFFFE53;

   localparam logic [31:0] LN2_Q26   = 32'd46516320;
   localparam logic [31:0] LN2_Q30   = 32'd744261118;
   localparam logic [31:0] LOG2E_Q24 = 32'd24204406;

   localparam logic signed [6:0] F_UNIFORM = 7'sd32;
   localparam logic signed [6:0] F_Q30     = 7'sd30;

   localparam logic [4:0] NORM_LAST = 5'd5;
   localparam logic [4:0] SQ_LAST   = 5'd29;
   localparam logic [4:0] MIX_LAST  = 5'd7;
   localparam logic [4:0] EXP_FIRST = 5'd1;
   localparam logic [4:0] EXP_LAST  = 5'd13;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_START,
      OP_MUL0,
      OP_MUL1,
      OP_MUL2,
      OP_MIXEND,
      OP_NORM,
      OP_MLOAD,
      OP_SQ,
      OP_LOGEND,
      OP_WM0,
      OP_WM1,
      OP_LNU_END,
      OP_LNA_END,
      OP_TL_END,
      OP_SCALE,
      OP_WLOAD,
      OP_LSUM,
      OP_EXPZ,
      OP_EXPA,
      OP_EXPB,
      OP_EXPC,
      OP_FINAL
   } op_type;

   typedef enum logic [1:0] {
      JOB_U,
      JOB_A,
      JOB_T,
      JOB_W
   } job_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] cnt;
      job_type    job;
   } cmd_type;

   // floor((2^32 - 1) / k)
   function automatic logic [31:0] recip(input logic [3:0] k);
      logic [31:0] r;
      case (k)
         4'd2:    r = 32'd2147483647;
         4'd3:    r = 32'd1431655765;
         4'd4:    r = 32'd1073741823;
         4'd5:    r = 32'd858993459;
         4'd6:    r = 32'd715827882;
         4'd7:    r = 32'd613566756;
         4'd8:    r = 32'd536870911;
         4'd9:    r = 32'd477218588;
         4'd10:   r = 32'd429496729;
         4'd11:   r = 32'd390451572;
         4'd12:   r = 32'd357913941;
         4'd13:   r = 32'd330382099;
         default: r = 32'hFFFFFFFF;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/gumbel_weight_perturber.sv */
// ----------------------------------------------------------------------------
// gumbel_weight_perturber
// Perturbs a prior weight by exp(noise_scale * g), g a Gumbel sample drawn
// from a splitmix64 generator.
//
// channel  ports                                      dir  item
// req      req_valid/req_stall, req_weight            in   Q7.24 weight
// rsp      rsp_valid/rsp_stall, rsp_perturbed,        out  Q24.24 result,
//          rsp_noise, rsp_saturated                        Q5.16 noise, flag
// csr      csr_write, csr_index, csr_data             in   register write
//
// Each item runs the splitmix64 mix, three logarithms (normalise, 30 squarings)
// and an exponential series, all on one shared 32x32 multiplier; a new weight
// is taken only once the previous item is finished.
// A finished item waits in the result register while the next one is worked;
// the next item holds in its last cycle while that result is stalled.
// Synchronous reset: seed 0, noise_scale 1.0, no item in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module gumbel_weight_perturber #(
   parameter int unsigned WEIGHT_FRAC_BITS = gwp_pkg::WEIGHT_FRAC_BITS_DEF,
   parameter int unsigned UNIFORM_BITS     = gwp_pkg::UNIFORM_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [31:0]                req_weight,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [47:0]                            rsp_perturbed,
   output logic signed [21:0]                     rsp_noise,
   output logic                                   rsp_saturated,
   input  wire logic                              csr_write,
   input  wire logic [gwp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [gwp_pkg::CSR_DATA_W-1:0]    csr_data
);

   gwp_pkg::cmd_type cmd;

   gwp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   gwp_datapath #(
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
      .UNIFORM_BITS     (UNIFORM_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_weight    (req_weight),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_perturbed (rsp_perturbed),
      .rsp_noise     (rsp_noise),
      .rsp_saturated (rsp_saturated)
   );

endmodule

`default_nettype wire

/* hw/rtl/gwp_ctrl.sv */
// ----------------------------------------------------------------------------
// gwp_ctrl
// Sequencer: steps the shared datapath through generator, logarithms,
// scaling and exponential, and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module gwp_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output gwp_pkg::cmd_type     cmd
);

   typedef enum logic [16:0] {
      S_IDLE   = 17'b00000000000000001,
      S_MIX    = 17'b00000000000000010,
      S_NORM   = 17'b00000000000000100,
      S_MLOAD  = 17'b00000000000001000,
      S_SQ     = 17'b00000000000010000,
      S_LOGEND = 17'b00000000000100000,
      S_WM0    = 17'b00000000001000000,
      S_WM1    = 17'b00000000010000000,
      S_WMEND  = 17'b00000000100000000,
      S_SCALE  = 17'b00000001000000000,
      S_WLOAD  = 17'b00000010000000000,
      S_LSUM   = 17'b00000100000000000,
      S_EXPZ   = 17'b00001000000000000,
      S_EXPA   = 17'b00010000000000000,
      S_EXPB   = 17'b00100000000000000,
      S_EXPC   = 17'b01000000000000000,
      S_FINAL  = 17'b10000000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [4:0]       cnt_ff, cnt_in;
   gwp_pkg::job_type job_ff, job_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      job_in       = job_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = gwp_pkg::OP_NONE;
      cmd.cnt      = cnt_ff;
      cmd.job      = job_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = gwp_pkg::OP_START;
               state_in = S_MIX;
               cnt_in   = '0;
               job_in   = gwp_pkg::JOB_U;
            end
         end
         S_MIX: begin
            case (cnt_ff[1:0])
               2'd0:    cmd.op = gwp_pkg::OP_MUL0;
               2'd1:    cmd.op = gwp_pkg::OP_MUL1;
               2'd2:    cmd.op = gwp_pkg::OP_MUL2;
               default: cmd.op = gwp_pkg::OP_MIXEND;
            endcase
            if (cnt_ff == gwp_pkg::MIX_LAST) begin
               state_in = S_NORM;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_NORM: begin
            cmd.op = gwp_pkg::OP_NORM;
            if (cnt_ff == gwp_pkg::NORM_LAST) begin
               state_in = S_MLOAD;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_MLOAD: begin
            cmd.op   = gwp_pkg::OP_MLOAD;
            state_in = S_SQ;
            cnt_in   = '0;
         end
         S_SQ: begin
            cmd.op = gwp_pkg::OP_SQ;
            if (cnt_ff == gwp_pkg::SQ_LAST) begin
               state_in = S_LOGEND;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_LOGEND: begin
            cmd.op   = gwp_pkg::OP_LOGEND;
            state_in = (job_ff == gwp_pkg::JOB_W) ? S_LSUM : S_WM0;
         end
         S_WM0: begin
            cmd.op   = gwp_pkg::OP_WM0;
            state_in = S_WM1;
         end
         S_WM1: begin
            cmd.op   = gwp_pkg::OP_WM1;
            state_in = S_WMEND;
         end
         S_WMEND: begin
            case (job_ff)
               gwp_pkg::JOB_U: begin
                  cmd.op   = gwp_pkg::OP_LNU_END;
                  state_in = S_NORM;
                  cnt_in   = '0;
                  job_in   = gwp_pkg::JOB_A;
               end
               gwp_pkg::JOB_A: begin
                  cmd.op   = gwp_pkg::OP_LNA_END;
                  state_in = S_SCALE;
               end
               default: begin
                  cmd.op   = gwp_pkg::OP_TL_END;
                  state_in = S_WLOAD;
                  job_in   = gwp_pkg::JOB_W;
               end
            endcase
         end
         S_SCALE: begin
            cmd.op   = gwp_pkg::OP_SCALE;
            state_in = S_WM0;
            job_in   = gwp_pkg::JOB_T;
         end
         S_WLOAD: begin
            cmd.op   = gwp_pkg::OP_WLOAD;
            state_in = S_NORM;
            cnt_in   = '0;
         end
         S_LSUM: begin
            cmd.op   = gwp_pkg::OP_LSUM;
            state_in = S_EXPZ;
         end
         S_EXPZ: begin
            cmd.op   = gwp_pkg::OP_EXPZ;
            state_in = S_EXPA;
            cnt_in   = gwp_pkg::EXP_FIRST;
         end
         S_EXPA: begin
            cmd.op   = gwp_pkg::OP_EXPA;
            state_in = S_EXPB;
         end
         S_EXPB: begin
            cmd.op   = gwp_pkg::OP_EXPB;
            state_in = S_EXPC;
         end
         S_EXPC: begin
            cmd.op = gwp_pkg::OP_EXPC;
            if (cnt_ff == gwp_pkg::EXP_LAST) begin
               state_in = S_FINAL;
            end else begin
               cnt_in   = cnt_ff + 5'd1;
               state_in = S_EXPA;
            end
         end
         S_FINAL: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = gwp_pkg::OP_FINAL;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         job_ff       <= gwp_pkg::JOB_U;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         job_ff       <= job_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/gwp_datapath.sv */
// ----------------------------------------------------------------------------
// gwp_datapath
// Generator state, one shared 32x32 multiplier and the working registers
// for logarithm, scaling and exponential; result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gwp_datapath #(
   parameter int unsigned WEIGHT_FRAC_BITS = gwp_pkg::WEIGHT_FRAC_BITS_DEF,
   parameter int unsigned UNIFORM_BITS     = gwp_pkg::UNIFORM_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire gwp_pkg::cmd_type                  cmd,
   input  wire logic signed [31:0]                req_weight,
   input  wire logic                              csr_write,
   input  wire logic [gwp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [gwp_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic [47:0]                            rsp_perturbed,
   output logic signed [21:0]                     rsp_noise,
   output logic                                   rsp_saturated
);

   localparam logic [31:0] FLOOR_RAW =
      32'(((64'd1 << WEIGHT_FRAC_BITS) + 64'd500000) / 64'd1000000);
   localparam logic [31:0] W_FLOOR = (FLOOR_RAW == 32'd0) ? 32'd1 : FLOOR_RAW;
   localparam logic [31:0] U_MASK  = ~32'((64'd1 << (32 - UNIFORM_BITS)) - 64'd1);
   localparam logic signed [6:0] F_WEIGHT = 7'(WEIGHT_FRAC_BITS);

   logic [63:0]        rng_ff, rng_in;
   logic [15:0]        scale_ff, scale_in;
   logic [63:0]        x_ff, x_in;
   logic [63:0]        y_ff, y_in;
   logic [31:0]        w_ff, w_in;
   logic [35:0]        nv_ff, nv_in;
   logic [5:0]         p_ff, p_in;
   logic [31:0]        m_ff, m_in;
   logic [29:0]        frac_ff, frac_in;
   logic signed [36:0] lg_ff, lg_in;
   logic [39:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [63:0]        acc_ff, acc_in;
   logic signed [21:0] g16_ff, g16_in;
   logic signed [47:0] tl_ff, tl_in;
   logic signed [47:0] el_ff, el_in;
   logic [29:0]        z_ff, z_in;
   logic [30:0]        term_ff, term_in;
   logic [30:0]        q_ff, q_in;
   logic [31:0]        est_ff, est_in;
   logic [32:0]        mant_ff, mant_in;
   logic [47:0]        per_ff, per_in;
   logic signed [21:0] noise_ff, noise_in;
   logic               sat_ff, sat_in;

   logic [31:0]        mul_a, mul_b;
   logic [63:0]        prod;
   logic [63:0]        mix_c;
   logic [31:0]        wcon;
   logic [63:0]        rsum;
   logic [45:0]        r;
   logic [21:0]        gabs;

   logic [63:0]        s_add, yz;
   logic [31:0]        u;
   logic               nzero;
   logic [5:0]         nsh;
   logic [33:0]        sq;
   logic signed [6:0]  fsel, ip;
   logic signed [36:0] lg;
   logic [36:0]        lg_abs;
   logic [45:0]        a_val;
   logic [32:0]        m16;
   logic [35:0]        ek, rem;
   logic [31:0]        estc;
   logic [3:0]         k;
   logic [30:0]        mantc;
   logic signed [17:0] n, s;
   logic [4:0]         shr;

   assign mix_c = cmd.cnt[2] ? gwp_pkg::MIX_C2 : gwp_pkg::MIX_C1;
   assign wcon  = (cmd.job == gwp_pkg::JOB_T) ? gwp_pkg::LOG2E_Q24 : gwp_pkg::LN2_Q26;
   assign gabs  = g16_ff[21] ? 22'(-g16_ff) : 22'(g16_ff);
   assign k     = cmd.cnt[3:0];

   always_comb begin
      case (cmd.op)
         gwp_pkg::OP_MUL0: begin
            mul_a = x_ff[31:0];
            mul_b = mix_c[31:0];
         end
         gwp_pkg::OP_MUL1: begin
            mul_a = x_ff[31:0];
            mul_b = mix_c[63:32];
         end
         gwp_pkg::OP_MUL2: begin
            mul_a = x_ff[63:32];
            mul_b = mix_c[31:0];
         end
         gwp_pkg::OP_SQ: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         gwp_pkg::OP_WM0: begin
            mul_a = mag_ff[31:0];
            mul_b = wcon;
         end
         gwp_pkg::OP_WM1: begin
            mul_a = {24'd0, mag_ff[39:32]};
            mul_b = wcon;
         end
         gwp_pkg::OP_SCALE: begin
            mul_a = {10'd0, gabs};
            mul_b = {16'd0, scale_ff};
         end
         gwp_pkg::OP_EXPZ: begin
            mul_a = {2'd0, el_ff[29:0]};
            mul_b = gwp_pkg::LN2_Q30;
         end
         gwp_pkg::OP_EXPA: begin
            mul_a = {1'b0, term_ff};
            mul_b = {2'd0, z_ff};
         end
         gwp_pkg::OP_EXPB: begin
            mul_a = {1'b0, q_ff};
            mul_b = gwp_pkg::recip(k);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      rsum = acc_ff + ((cmd.job == gwp_pkg::JOB_T) ? (64'd1 << 17) : (64'd1 << 25));
      r    = (cmd.job == gwp_pkg::JOB_T) ? 46'(rsum >> 18) : 46'(rsum >> 26);
   end

   always_comb begin
      rng_in   = rng_ff;
      scale_in = scale_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      w_in     = w_ff;
      nv_in    = nv_ff;
      p_in     = p_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      lg_in    = lg_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      g16_in   = g16_ff;
      tl_in    = tl_ff;
      el_in    = el_ff;
      z_in     = z_ff;
      term_in  = term_ff;
      q_in     = q_ff;
      est_in   = est_ff;
      mant_in  = mant_ff;
      per_in   = per_ff;
      noise_in = noise_ff;
      sat_in   = sat_ff;

      s_add  = rng_ff + gwp_pkg::GOLDEN;
      yz     = y_ff ^ (y_ff >> 31);
      u      = yz[63:32] & U_MASK;
      nzero  = 1'b0;
      nsh    = 6'd32 >> cmd.cnt[2:0];
      sq     = prod[63:30];
      case (cmd.job)
         gwp_pkg::JOB_U: fsel = gwp_pkg::F_UNIFORM;
         gwp_pkg::JOB_A: fsel = gwp_pkg::F_Q30;
         default:        fsel = F_WEIGHT;
      endcase
      ip     = $signed({1'b0, p_ff}) - fsel;
      lg     = {ip, frac_ff};
      lg_abs = lg[36] ? 37'(-lg) : 37'(lg);
      a_val  = (neg_ff && (r != '0)) ? r : 46'd0;
      m16    = 33'((47'(r) + 47'd8192) >> 14);
      ek     = 36'(est_ff) * 36'(k);
      rem    = 36'(q_ff) - ek;
      estc   = (rem >= 36'(k)) ? est_ff + 32'd1 : est_ff;
      mantc  = (mant_ff > 33'h07FFFFFFF) ? 31'h7FFFFFFF : mant_ff[30:0];
      n      = el_ff[47:30];
      s      = n - 18'sd6;
      shr    = 5'(-s);

      case (cmd.op)
         gwp_pkg::OP_START: begin
            w_in   = ($signed(req_weight) < $signed(W_FLOOR)) ? W_FLOOR : 32'(req_weight);
            rng_in = s_add;
            x_in   = s_add ^ (s_add >> 30);
         end
         gwp_pkg::OP_MUL0: begin
            y_in = prod;
         end
         gwp_pkg::OP_MUL1, gwp_pkg::OP_MUL2: begin
            y_in = {y_ff[63:32] + prod[31:0], y_ff[31:0]};
         end
         gwp_pkg::OP_MIXEND: begin
            if (!cmd.cnt[2]) begin
               x_in = y_ff ^ (y_ff >> 27);
            end else begin
               if (u < gwp_pkg::U_LO) begin
                  nv_in = {4'd0, gwp_pkg::U_LO};
               end else if (u > gwp_pkg::U_HI) begin
                  nv_in = {4'd0, gwp_pkg::U_HI};
               end else begin
                  nv_in = {4'd0, u};
               end
               p_in = 6'd35;
            end
         end
         gwp_pkg::OP_NORM: begin
            case (cmd.cnt[2:0])
               3'd0:    nzero = (nv_ff[35:4] == '0);
               3'd1:    nzero = (nv_ff[35:20] == '0);
               3'd2:    nzero = (nv_ff[35:28] == '0);
               3'd3:    nzero = (nv_ff[35:32] == '0);
               3'd4:    nzero = (nv_ff[35:34] == '0);
               default: nzero = !nv_ff[35];
            endcase
            if (nzero) begin
               nv_in = nv_ff << nsh;
               p_in  = p_ff - nsh;
            end
         end
         gwp_pkg::OP_MLOAD: begin
            m_in    = {1'b0, nv_ff[35:5]};
            frac_in = '0;
         end
         gwp_pkg::OP_SQ: begin
            if (sq[31]) begin
               m_in    = sq[32:1];
               frac_in = frac_ff | (30'd1 << (5'd29 - cmd.cnt));
            end else begin
               m_in = sq[31:0];
            end
         end
         gwp_pkg::OP_LOGEND: begin
            lg_in  = lg;
            mag_in = {3'd0, lg_abs};
            neg_in = lg[36];
         end
         gwp_pkg::OP_WM0: begin
            acc_in = prod;
         end
         gwp_pkg::OP_WM1: begin
            acc_in = acc_ff + {prod[31:0], 32'd0};
         end
         gwp_pkg::OP_LNU_END: begin
            nv_in = (a_val == '0) ? 36'd1 : a_val[35:0];
            p_in  = 6'd35;
         end
         gwp_pkg::OP_LNA_END: begin
            if (neg_ff) begin
               g16_in = (m16 > 33'd2097151) ? 22'sh1FFFFF : $signed(m16[21:0]);
            end else begin
               g16_in = (m16 > 33'd2097152) ? 22'sh200000 : $signed(22'(-m16[21:0]));
            end
         end
         gwp_pkg::OP_SCALE: begin
            mag_in = prod[39:0];
            neg_in = g16_ff[21];
         end
         gwp_pkg::OP_TL_END: begin
            tl_in = neg_ff ? -$signed(48'(r)) : $signed(48'(r));
         end
         gwp_pkg::OP_WLOAD: begin
            nv_in = {4'd0, w_ff};
            p_in  = 6'd35;
         end
         gwp_pkg::OP_LSUM: begin
            el_in = {{11{lg_ff[36]}}, lg_ff} + tl_ff;
         end
         gwp_pkg::OP_EXPZ: begin
            z_in    = prod[59:30];
            term_in = 31'h40000000;
            mant_in = 33'h040000000;
         end
         gwp_pkg::OP_EXPA: begin
            q_in = prod[60:30];
         end
         gwp_pkg::OP_EXPB: begin
            est_in = prod[63:32];
         end
         gwp_pkg::OP_EXPC: begin
            term_in = estc[30:0];
            mant_in = mant_ff + 33'(estc);
         end
         gwp_pkg::OP_FINAL: begin
            noise_in = g16_ff;
            sat_in   = 1'b0;
            if (n >= 18'sd24) begin
               per_in = '1;
               sat_in = 1'b1;
            end else if (!s[17]) begin
               per_in = 48'(mantc) << s[4:0];
            end else if (s <= -18'sd32) begin
               per_in = '0;
            end else begin
               per_in = 48'((33'(mantc) + (33'd1 << (shr - 5'd1))) >> shr);
            end
         end
         default: begin
         end
      endcase

      if (csr_write) begin
         case (csr_index)
            gwp_pkg::REG_NOISE_SCALE: scale_in = csr_data[15:0];
            gwp_pkg::REG_SEED:        rng_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rng_ff   <= '0;
         scale_ff <= gwp_pkg::NOISE_SCALE_RESET;
      end else begin
         rng_ff   <= rng_in;
         scale_ff <= scale_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      w_ff     <= w_in;
      nv_ff    <= nv_in;
      p_ff     <= p_in;
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      lg_ff    <= lg_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
      g16_ff   <= g16_in;
      tl_ff    <= tl_in;
      el_ff    <= el_in;
      z_ff     <= z_in;
      term_ff  <= term_in;
      q_ff     <= q_in;
      est_ff   <= est_in;
      mant_ff  <= mant_in;
      per_ff   <= per_in;
      noise_ff <= noise_in;
      sat_ff   <= sat_in;
   end

   assign rsp_perturbed = per_ff;
   assign rsp_noise     = noise_ff;
   assign rsp_saturated = sat_ff;

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gumbel_weight_perturber. Weights are sent with random
// gaps and results taken with random stalls (neither in the quiet phase); every
// result is checked against a bit-exact fixed-point splitmix64/Gumbel/exp model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint W_FLOOR  = ((64'd1 << 24) + 500000) / 1000000;
   localparam longint ONE_Q30  = 64'sd1 << 30;
   localparam longint unsigned OUT_MAX = (64'd1 << 48) - 1;
   localparam int     IDLE_LIMIT = 5000;
   localparam int     RANDOM_PER_PHASE = 100;

   typedef struct {
      logic [47:0]        perturbed;
      logic signed [21:0] noise;
      logic               saturated;
   } result_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic signed [31:0]                    req_weight = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic [47:0]                           rsp_perturbed;
   logic signed [21:0]                    rsp_noise;
   logic                                  rsp_saturated;
   logic                                  csr_write = 1'b0;
   logic [gwp_pkg::CSR_INDEX_W-1:0]       csr_index = gwp_pkg::REG_NOISE_SCALE;
   logic [gwp_pkg::CSR_DATA_W-1:0]        csr_data = '0;

   result_type           expect_fifo[16];
   int unsigned          expect_wr = 0;
   int unsigned          expect_rd = 0;
   longint unsigned      model_scale = gwp_pkg::NOISE_SCALE_RESET;
   longint unsigned      model_rng = '0;
   int                   errors = 0;
   int                   idle_cycles = 0;
   bit                   quiet = 1'b0;
   int                   stall_left = 0;

   logic signed [31:0] directed_weights[] = '{
      32'sd0, 32'sd1, 32'sd16, 32'sd17, 32'sd18, -32'sd1, 32'sh80000000,
      32'sh7FFFFFFF, 32'sh01000000, 32'sh00000100, 32'sh40000000,
      32'sh55555555, 32'shAAAAAAAA, 32'sh7F000000, 32'sd2, 32'sh01000001,
      32'sh00FFFFFF, 32'sh00001000, 32'sh20000000, 32'shFFFFFF00
   };

   gumbel_weight_perturber uut (
      .clock, .reset, .req_valid, .req_stall, .req_weight,
      .rsp_valid, .rsp_stall, .rsp_perturbed, .rsp_noise, .rsp_saturated,
      .csr_write, .csr_index, .csr_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint scale_round(longint a, longint unsigned c, int sh);
      bit              neg;
      longint unsigned mag;
      longint unsigned r;
      neg = a < 0;
      mag = neg ? -a : a;
      r = (mag * c + (64'd1 << (sh - 1))) >> sh;
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint log2_fixed(longint unsigned v, int f);
      int              p;
      longint unsigned m;
      longint unsigned frac;
      p = 63;
      frac = 0;
      while (p > 0 && v[p] == 1'b0) p--;
      m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
      for (int i = 0; i < 30; i++) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac |= 64'd1 << (29 - i);
         end
      end
      return longint'(p - f) * ONE_Q30 + longint'(frac);
   endfunction

   function automatic longint ln_fixed(longint unsigned v, int f);
      return scale_round(log2_fixed(v, f), gwp_pkg::LN2_Q26, 26);
   endfunction

   function automatic longint unsigned splitmix_next();
      longint unsigned z;
      model_rng += gwp_pkg::GOLDEN;
      z = model_rng;
      z = (z ^ (z >> 30)) * gwp_pkg::MIX_C1;
      z = (z ^ (z >> 27)) * gwp_pkg::MIX_C2;
      return z ^ (z >> 31);
   endfunction

   function automatic result_type perturb_weight(logic signed [31:0] w_in);
      result_type      res;
      longint          w, lnu, g30, g16, t24, lsum, n, s;
      longint unsigned u, a, f, z, term, mant, val;
      w = w_in;
      if (w < W_FLOOR) w = W_FLOOR;
      u = (splitmix_next() >> 40) << 8;
      if (u < gwp_pkg::U_LO) u = gwp_pkg::U_LO;
      if (u > (64'd1 << 32) - gwp_pkg::U_LO) u = (64'd1 << 32) - gwp_pkg::U_LO;
      lnu = ln_fixed(u, 32);
      a = (lnu < 0) ? -lnu : 0;
      if (a < 1) a = 1;
      g30 = -ln_fixed(a, 30);
      g16 = scale_round(g30, 1, 14);
      if (g16 > 2097151) g16 = 2097151;
      if (g16 < -2097152) g16 = -2097152;
      t24 = g16 * longint'(model_scale);
      lsum = log2_fixed(w, 24) + scale_round(t24, gwp_pkg::LOG2E_Q24, 18);
      f = lsum & 64'h3FFFFFFF;
      n = (lsum - longint'(f)) >>> 30;
      res.saturated = 1'b0;
      if (n >= 24) begin
         res.saturated = 1'b1;
         val = OUT_MAX;
      end else begin
         z = (f * gwp_pkg::LN2_Q30) >> 30;
         term = 64'd1 << 30;
         mant = term;
         for (int k = 1; k <= 13; k++) begin
            term = ((term * z) >> 30) / longint'(k);
            mant += term;
         end
         if (mant > (64'd1 << 31) - 1) mant = (64'd1 << 31) - 1;
         s = n - 6;
         if (s >= 0) val = mant << s;
         else if (s <= -32) val = 0;
         else val = (mant + (64'd1 << (-s - 1))) >> (-s);
         if (val > OUT_MAX) begin
            val = OUT_MAX;
            res.saturated = 1'b1;
         end
      end
      res.perturbed = val[47:0];
      res.noise = g16[21:0];
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [31:0] random_weight();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 40);
         1:       return -$signed({1'b0, 31'($urandom())});
         2:       return $urandom_range(32'h00800000, 32'h02000000);
         3:       return 32'h7F000000 | 32'($urandom_range(0, 32'h00FFFFFF));
         default: return $urandom();
      endcase
   endfunction

   // model and checker: sample at the rising edge
   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         model_scale = gwp_pkg::NOISE_SCALE_RESET;
         model_rng = '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               gwp_pkg::REG_NOISE_SCALE: model_scale = csr_data[15:0];
               gwp_pkg::REG_SEED:        model_rng = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expect_fifo[expect_wr[3:0]] = perturb_weight(req_weight);
            expect_wr++;
         end
         if (rsp_valid && !rsp_stall) begin
            got.perturbed = rsp_perturbed;
            got.noise = rsp_noise;
            got.saturated = rsp_saturated;
            if (expect_wr == expect_rd) begin
               $display("%0t: unexpected item perturbed=%h noise=%h sat=%b",
                        $realtime, got.perturbed, got.noise, got.saturated);
               errors++;
            end else begin
               want = expect_fifo[expect_rd[3:0]];
               expect_rd++;
               if (got.perturbed !== want.perturbed) begin
                  $display("%0t: perturbed expected %h actual %h",
                           $realtime, want.perturbed, got.perturbed);
                  errors++;
               end
               if (got.noise !== want.noise) begin
                  $display("%0t: noise expected %h actual %h",
                           $realtime, want.noise, got.noise);
                  errors++;
               end
               if (got.saturated !== want.saturated) begin
                  $display("%0t: saturated expected %b actual %b",
                           $realtime, want.saturated, got.saturated);
                  errors++;
               end
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_stall = stall_left > 0;
         if (stall_left > 0) stall_left--;
      end
   end

   task automatic send_weight(logic signed [31:0] w);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_weight = w;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(logic [gwp_pkg::CSR_INDEX_W-1:0] idx, logic [63:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expect_wr != expect_rd) @(negedge clock);
   endtask

   task automatic run_phase(logic [15:0] scale, logic [63:0] seed_val, bit with_table);
      drain();
      write_reg(gwp_pkg::REG_NOISE_SCALE, {48'($urandom()), scale});
      write_reg(gwp_pkg::REG_SEED, seed_val);
      if (with_table)
         foreach (directed_weights[i]) send_weight(directed_weights[i]);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_weight(random_weight());
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset = 1'b0;
      foreach (directed_weights[i]) send_weight(directed_weights[i]);
      run_phase(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      run_phase(16'h0000, 64'h0, 1'b0);
      quiet = 1'b1;
      run_phase(16'h0001, {$urandom(), $urandom()}, 1'b0);
      quiet = 1'b0;
      run_phase(16'h0080, {$urandom(), $urandom()}, 1'b0);
      run_phase(16'($urandom()), {$urandom(), $urandom()}, 1'b0);
      run_phase(16'h0100, {$urandom(), $urandom()}, 1'b0);
      drain();
      repeat (200) @(negedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/gwp_pkg.sv
hw/rtl/gwp_ctrl.sv
hw/rtl/gwp_datapath.sv
hw/rtl/gumbel_weight_perturber.sv
tb/tb.sv
